// ===== design/ekd_pkg.sv =====
`timescale 1ns / 1ps

package ekd_pkg;

  typedef enum logic [1:0] {
    CMD_OFFER   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2,
    PH_SS3  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    KEY_NONE  = 4'd0,
    KEY_0     = 4'd1,
    KEY_1     = 4'd2,
    KEY_9     = 4'd3,
    KEY_W     = 4'd4,
    KEY_S     = 4'd5,
    KEY_A     = 4'd6,
    KEY_D     = 4'd7,
    KEY_Q     = 4'd8,
    KEY_E     = 4'd9,
    KEY_SPACE = 4'd10,
    KEY_P     = 4'd11,
    KEY_R     = 4'd12,
    KEY_H     = 4'd13,
    KEY_ENTER = 4'd14
  } key_t;

  localparam logic [7:0] ESC_BYTE     = 8'd27;
  localparam logic [7:0] CSI_END_LOW  = 8'h40;
  localparam logic [7:0] CSI_END_HIGH = 8'h7e;
  localparam logic [7:0] CSI_OPEN     = 8'h5b;
  localparam logic [7:0] SS3_OPEN     = 8'h4f;

  typedef struct packed {
    phase_t     phase_nxt;
    logic [3:0] key_nxt;
    logic       accepted;
    logic       new_key;
  } step_t;

  function automatic logic [3:0] map_key(input logic [7:0] c);
    logic [7:0] u;
    logic [3:0] k;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'h20;
    end
    case (u)
      8'h30:   k = KEY_0;
      8'h31:   k = KEY_1;
      8'h39:   k = KEY_9;
      8'h57:   k = KEY_W;
      8'h53:   k = KEY_S;
      8'h41:   k = KEY_A;
      8'h44:   k = KEY_D;
      8'h51:   k = KEY_Q;
      8'h45:   k = KEY_E;
      8'h20:   k = KEY_SPACE;
      8'h50:   k = KEY_P;
      8'h52:   k = KEY_R;
      8'h48:   k = KEY_H;
      8'h0a,
      8'h0d:   k = KEY_ENTER;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== design/ekd_if.sv =====
`timescale 1ns / 1ps

interface ekd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_in;

  modport source (output valid, output command, output byte_in, input ready);
  modport sink (input valid, input command, input byte_in, output ready);
endinterface

interface ekd_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       new_key;
  logic [3:0] held_key;

  modport source (output valid, output accepted, output new_key, output held_key,
                  input ready);
  modport sink (input valid, input accepted, input new_key, input held_key,
                output ready);
endinterface

// ===== design/ekd_step.sv =====
`timescale 1ns / 1ps

module ekd_step import ekd_pkg::*; (
  input  phase_t     phase,
  input  logic [3:0] key,
  input  logic [1:0] command,
  input  logic [7:0] byte_in,
  output step_t      step
);

  logic [3:0] mapped;

  assign mapped = map_key(byte_in);

  always_comb begin
    step.phase_nxt = phase;
    step.key_nxt   = key;
    step.accepted  = 1'b0;
    step.new_key   = 1'b0;
    case (command)
      CMD_OFFER: begin
        if (key == KEY_NONE) begin
          step.accepted = 1'b1;
          if (byte_in == ESC_BYTE) begin
            step.phase_nxt = PH_ESC;
          end else begin
            unique case (phase)
              PH_ESC: begin
                if (byte_in == CSI_OPEN) begin
                  step.phase_nxt = PH_CSI;
                end else if (byte_in == SS3_OPEN) begin
                  step.phase_nxt = PH_SS3;
                end else begin
                  step.phase_nxt = PH_IDLE;
                end
              end
              PH_CSI: begin
                if (byte_in >= CSI_END_LOW && byte_in <= CSI_END_HIGH) begin
                  step.phase_nxt = PH_IDLE;
                end
              end
              PH_SS3: begin
                step.phase_nxt = PH_IDLE;
              end
              default: begin
                if (mapped != KEY_NONE) begin
                  step.key_nxt = mapped;
                  step.new_key = 1'b1;
                end
              end
            endcase
          end
        end
      end
      CMD_CLEAR: begin
        step.key_nxt = KEY_NONE;
      end
      CMD_RESTART: begin
        step.phase_nxt = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/escape_filtering_key_decoder.sv =====
`timescale 1ns / 1ps

// Terminal key decoder with ANSI escape filtering. Each item on in_chan is a
// command (offer byte, clear held key, restart escape tracking) and gives
// exactly one result item on out_chan. An item is taken every cycle as long
// as the result register is empty or being drained; the registered result
// appears in the cycle after acceptance. The escape phase and the held key are
// updated at acceptance, so items may follow back to back. While a key is
// held, an offered byte comes back with accepted low and must be offered
// again after a clear.

module escape_filtering_key_decoder import ekd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ekd_in_if.sink     in_chan,
  ekd_out_if.source  out_chan
);

  phase_t     phase_r;
  logic [3:0] key_r;
  logic       out_valid_r;
  logic       accepted_r;
  logic       new_key_r;
  logic [3:0] held_key_r;
  step_t      step;
  logic       take;

  ekd_step u_step (
    .phase   (phase_r),
    .key     (key_r),
    .command (in_chan.command),
    .byte_in (in_chan.byte_in),
    .step    (step)
  );

  assign in_chan.ready     = !out_valid_r || out_chan.ready;
  assign take              = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.accepted = accepted_r;
  assign out_chan.new_key  = new_key_r;
  assign out_chan.held_key = held_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      key_r       <= KEY_NONE;
      out_valid_r <= 1'b0;
    end else if (take) begin
      phase_r     <= step.phase_nxt;
      key_r       <= step.key_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted_r <= step.accepted;
      new_key_r  <= step.new_key;
      held_key_r <= step.key_nxt;
    end
  end

  a_clear_drops_key: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_chan.command == CMD_CLEAR |=> key_r == KEY_NONE)
    else $error("clear left a key held");

  a_restart_idles: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_chan.command == CMD_RESTART |=> phase_r == PH_IDLE)
    else $error("restart left escape phase active");

  a_held_refuses: assert property (@(posedge clk) disable iff (!rst_n)
    take && key_r != KEY_NONE |=> !accepted_r && !new_key_r)
    else $error("byte consumed while key held");

  a_new_key_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && new_key_r |-> accepted_r && held_key_r != KEY_NONE)
    else $error("new key without accepted byte");

  a_key_matches: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> held_key_r == key_r)
    else $error("result key differs from held key");

endmodule
